@@ design/hler_pkg.sv @@
package hler_pkg;

  localparam int CoordW    = 12;
  localparam int DeltaW    = 13;
  localparam int IdxW      = 8;
  localparam int NumVtx    = 256;
  localparam int NumFace   = 256;
  localparam int Corners   = 3;
  localparam int NumEdge   = NumFace * Corners;
  localparam int VtxAW     = $clog2(NumVtx);
  localparam int FaceAW    = $clog2(NumFace);
  localparam int EdgeAW    = $clog2(NumEdge);
  localparam int FcW       = 9;
  localparam int EdgeValW  = 32;
  localparam int DivW      = 26;
  localparam int DivisorW  = 12;
  localparam int DivCntW   = $clog2(DivW + 1);
  localparam int PzW       = 28;
  localparam int InDataW   = 72;
  localparam int OutDataW  = 32;
  localparam int FlatPlaneZ  = -1000;
  localparam int DepthMargin = -1;

  typedef enum logic [1:0] {
    KIND_VTX   = 2'd0,
    KIND_FACE  = 2'd1,
    KIND_START = 2'd2,
    KIND_STEP  = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nx;
    logic [IdxW-1:0]          c2;
    logic [IdxW-1:0]          c1;
    logic [IdxW-1:0]          c0;
  } face_t;

  typedef struct packed {
    logic signed [DeltaW-1:0]   dy;
    logic signed [DeltaW-1:0]   dx;
    logic signed [EdgeValW-1:0] val;
  } edge_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_SA, OP_SB, OP_SC, OP_SD,
    OP_F0, OP_F1, OP_F2, OP_F3, OP_F4,
    OP_E0, OP_E1, OP_E2, OP_E3,
    OP_V0, OP_V1, OP_V2, OP_V3, OP_V4,
    OP_M0, OP_M1, OP_M2, OP_DS, OP_DW, OP_DC,
    OP_OUT, OP_ADV, OP_UPD
  } op_e;

  typedef struct packed {
    op_e  op;
    logic accept;
    logic face_inc;
    logic clr_vis;
  } cmd_t;

  typedef struct packed {
    logic nf_zero;
    logic face_last;
    logic corner_last;
    logic active;
    logic skip;
    logic flat;
    logic hidden;
    logic div_busy;
    logic out_free;
    logic upd_done;
    logic last_pix;
  } sts_t;

endpackage

@@ design/hidden_line_edge_rasterizer.sv @@
// Channel      | Direction | Handshake               | Contents
// s_axis       | in        | s_axis_tvalid/tready    | tuser kind, tdata geometry item
// m_axis       | out       | m_axis_tvalid/tready    | tdata pixel, tlast end of edge
// cfg          | in        | cfg_we_i                | face count (9 bit)
//
// Vertex and face loads go straight into their memories and leave the input ready. A start
// edge fetches, for each face, the face and its corners, then runs an edge-function
// setup per corner through the shared multiplier.
// A step reads the face and edge memories for each face tested; each covering face that is
// not flat and shares at most one corner with the edge also takes the depth multiplies and
// the 26-bit serial divider, and an incremental edge-function pass over the edge memory
// follows the face tests. Reset clears the walk and the face count; the memories are not cleared.
// A held result in the output register stalls the next step only when that step is ready
// to present its pixel.
module hidden_line_edge_rasterizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] slot, [19:8] coord_x, [31:20] coord_y, [43:32] coord_z,
  // [51:44] vertex_a, [59:52] vertex_b, [67:60] vertex_c
  input  logic [71:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [24] visible
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  hler_pkg::cmd_t cmd;
  hler_pkg::sts_t sts;

  hler_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  hler_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ design/hler_ram.sv @@
module hler_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/hler_div.sv @@
module hler_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hler_pkg::DivW-1:0]     dividend_i,
  input  logic [hler_pkg::DivisorW-1:0] divisor_i,
  output logic                          busy_o,
  output logic [hler_pkg::DivW-1:0]     quotient_o
);

  logic                          busy_q, busy_d;
  logic [hler_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [hler_pkg::DivW-1:0]     dvd_q, dvd_d;
  logic [hler_pkg::DivW-1:0]     quo_q, quo_d;
  logic [hler_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [hler_pkg::DivisorW-1:0] dvs_q, dvs_d;
  logic [hler_pkg::DivisorW:0]   rem_sh;
  logic                          fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, dvd_q[hler_pkg::DivW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? hler_pkg::DivisorW'(rem_sh - {1'b0, dvs_q})
                   : rem_sh[hler_pkg::DivisorW-1:0];
      quo_d = {quo_q[hler_pkg::DivW-2:0], fits};
      dvd_d = {dvd_q[hler_pkg::DivW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == hler_pkg::DivCntW'(hler_pkg::DivW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ design/hler_ctrl.sv @@
module hler_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          kind_i,
  input  hler_pkg::sts_t      sts_i,
  output hler_pkg::cmd_t      cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE = 28'h0000001, S_SA  = 28'h0000002, S_SB  = 28'h0000004,
    S_SC   = 28'h0000008, S_SD  = 28'h0000010, S_F0  = 28'h0000020,
    S_F1   = 28'h0000040, S_F2  = 28'h0000080, S_F3  = 28'h0000100,
    S_F4   = 28'h0000200, S_E0  = 28'h0000400, S_E1  = 28'h0000800,
    S_E2   = 28'h0001000, S_E3  = 28'h0002000, S_V0  = 28'h0004000,
    S_V1   = 28'h0008000, S_V2  = 28'h0010000, S_V3  = 28'h0020000,
    S_V4   = 28'h0040000, S_M0  = 28'h0080000, S_M1  = 28'h0100000,
    S_M2   = 28'h0200000, S_DS  = 28'h0400000, S_DW  = 28'h0800000,
    S_DC   = 28'h1000000, S_OUT = 28'h2000000, S_ADV = 28'h4000000,
    S_UPD  = 28'h8000000
  } state_e;

  state_e state_q, state_d;
  hler_pkg::kind_e kind;

  assign kind = hler_pkg::kind_e'(kind_i);
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = hler_pkg::OP_IDLE;
    cmd_o.accept = 1'b0;
    cmd_o.face_inc = 1'b0;
    cmd_o.clr_vis  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op = hler_pkg::OP_IDLE;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          unique case (kind)
            hler_pkg::KIND_START: state_d = S_SA;
            hler_pkg::KIND_STEP: begin
              if (sts_i.active) begin
                state_d = sts_i.nf_zero ? S_OUT : S_V0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SA: begin cmd_o.op = hler_pkg::OP_SA; state_d = S_SB; end
      S_SB: begin cmd_o.op = hler_pkg::OP_SB; state_d = S_SC; end
      S_SC: begin cmd_o.op = hler_pkg::OP_SC; state_d = S_SD; end
      S_SD: begin
        cmd_o.op = hler_pkg::OP_SD;
        state_d  = sts_i.nf_zero ? S_IDLE : S_F0;
      end
      S_F0: begin cmd_o.op = hler_pkg::OP_F0; state_d = S_F1; end
      S_F1: begin cmd_o.op = hler_pkg::OP_F1; state_d = S_F2; end
      S_F2: begin cmd_o.op = hler_pkg::OP_F2; state_d = S_F3; end
      S_F3: begin cmd_o.op = hler_pkg::OP_F3; state_d = S_F4; end
      S_F4: begin cmd_o.op = hler_pkg::OP_F4; state_d = S_E0; end
      S_E0: begin cmd_o.op = hler_pkg::OP_E0; state_d = S_E1; end
      S_E1: begin cmd_o.op = hler_pkg::OP_E1; state_d = S_E2; end
      S_E2: begin cmd_o.op = hler_pkg::OP_E2; state_d = S_E3; end
      S_E3: begin
        cmd_o.op = hler_pkg::OP_E3;
        priority if (!sts_i.corner_last) state_d = S_E0;
        else if (sts_i.face_last)        state_d = S_IDLE;
        else                             state_d = S_F0;
      end
      S_V0: begin cmd_o.op = hler_pkg::OP_V0; state_d = S_V1; end
      S_V1: begin cmd_o.op = hler_pkg::OP_V1; state_d = S_V2; end
      S_V2: begin cmd_o.op = hler_pkg::OP_V2; state_d = S_V3; end
      S_V3: begin
        cmd_o.op = hler_pkg::OP_V3;
        priority if (sts_i.skip || (sts_i.flat && !sts_i.hidden)) begin
          cmd_o.face_inc = 1'b1;
          state_d = sts_i.face_last ? S_OUT : S_V0;
        end else if (sts_i.flat) begin
          cmd_o.clr_vis = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_V4;
        end
      end
      S_V4: begin cmd_o.op = hler_pkg::OP_V4; state_d = S_M0; end
      S_M0: begin cmd_o.op = hler_pkg::OP_M0; state_d = S_M1; end
      S_M1: begin cmd_o.op = hler_pkg::OP_M1; state_d = S_M2; end
      S_M2: begin cmd_o.op = hler_pkg::OP_M2; state_d = S_DS; end
      S_DS: begin cmd_o.op = hler_pkg::OP_DS; state_d = S_DW; end
      S_DW: begin
        cmd_o.op = hler_pkg::OP_DW;
        state_d  = sts_i.div_busy ? S_DW : S_DC;
      end
      S_DC: begin
        cmd_o.op = hler_pkg::OP_DC;
        if (sts_i.hidden) begin
          cmd_o.clr_vis = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.face_inc = 1'b1;
          state_d = sts_i.face_last ? S_OUT : S_V0;
        end
      end
      S_OUT: begin
        cmd_o.op = hler_pkg::OP_OUT;
        if (sts_i.out_free) begin
          state_d = sts_i.last_pix ? S_IDLE : S_ADV;
        end
      end
      S_ADV: begin cmd_o.op = hler_pkg::OP_ADV; state_d = S_UPD; end
      S_UPD: begin
        cmd_o.op = hler_pkg::OP_UPD;
        if (sts_i.upd_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/hler_dp.sv @@
module hler_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hler_pkg::cmd_t                   cmd_i,
  output hler_pkg::sts_t                   sts_o,
  input  logic [hler_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [hler_pkg::FcW-1:0]         cfg_wdata_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hler_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);

  localparam int CW = hler_pkg::CoordW;
  localparam int DW = hler_pkg::DeltaW;
  localparam int IW = hler_pkg::IdxW;
  localparam int VW = hler_pkg::EdgeValW;

  // input item fields
  logic [IW-1:0]         in_slot, in_va, in_vb, in_vc;
  logic signed [CW-1:0]  in_x, in_y, in_z;
  hler_pkg::kind_e       in_kind;

  assign in_slot = s_axis_tdata[7:0];
  assign in_x    = s_axis_tdata[19:8];
  assign in_y    = s_axis_tdata[31:20];
  assign in_z    = s_axis_tdata[43:32];
  assign in_va   = s_axis_tdata[51:44];
  assign in_vb   = s_axis_tdata[59:52];
  assign in_vc   = s_axis_tdata[67:60];
  assign in_kind = hler_pkg::kind_e'(s_axis_tuser);

  logic [hler_pkg::FcW-1:0] fc_q, nf;
  logic [IW-1:0]            va_q, vb_q, ep_a_q, ep_b_q;

  // walk state
  logic signed [CW-1:0] pos_q [3];
  logic signed [DW-1:0] err_q [3];
  logic [CW-1:0]        dlt_q [3];
  logic                 sneg_q [3];
  logic [CW-1:0]        major_q, steps_q;
  logic                 active_q, mvx_q, mvy_q;

  // per-face work registers
  logic [hler_pkg::FcW-1:0]  f_q;
  logic [1:0]                cidx_q;
  logic [hler_pkg::EdgeAW-1:0] eaddr_q, wa_q;
  logic                      pv_q;
  hler_pkg::face_t           face_q;
  hler_pkg::vertex_t         vtx_q [3];
  logic signed [DW-1:0]      ex_q, ey_q, rx_q, ry_q;
  logic signed [VW-1:0]      acc_q;
  logic                      inside_q, vis_q;

  // output register
  logic                      mo_valid_q, mo_vis_q, mo_last_q;
  logic signed [CW-1:0]      mo_x_q, mo_y_q;

  // memories
  hler_pkg::vertex_t vrd;
  hler_pkg::face_t   frd;
  hler_pkg::edge_t   erd, ewd;
  logic [hler_pkg::VtxAW-1:0]  v_raddr;
  logic [hler_pkg::EdgeAW-1:0] e_waddr;
  logic                        e_we;
  hler_pkg::vertex_t vwd;
  hler_pkg::face_t   fwd;

  assign vwd = '{z: in_z, y: in_y, x: in_x};
  assign fwd = '{nz: in_z, ny: in_y, nx: in_x, c2: in_vc, c1: in_vb, c0: in_va};

  hler_ram #(.Width($bits(hler_pkg::vertex_t)), .Depth(hler_pkg::NumVtx)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && in_kind == hler_pkg::KIND_VTX),
    .waddr_i (in_slot),
    .wdata_i (vwd),
    .raddr_i (v_raddr),
    .rdata_o (vrd)
  );

  hler_ram #(.Width($bits(hler_pkg::face_t)), .Depth(hler_pkg::NumFace)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && in_kind == hler_pkg::KIND_FACE),
    .waddr_i (in_slot),
    .wdata_i (fwd),
    .raddr_i (f_q[hler_pkg::FaceAW-1:0]),
    .rdata_o (frd)
  );

  hler_ram #(.Width($bits(hler_pkg::edge_t)), .Depth(hler_pkg::NumEdge)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (ewd),
    .raddr_i (eaddr_q),
    .rdata_o (erd)
  );

  // divider for the plane depth
  logic [hler_pkg::DivW-1:0]     quo;
  logic [VW-1:0]                 acc_mag;
  logic signed [DW-1:0]          nz13, nz_mag;
  logic                          div_busy;

  assign acc_mag = acc_q[VW-1] ? VW'(-acc_q) : VW'(acc_q);
  assign nz13    = DW'(face_q.nz);
  assign nz_mag  = nz13[DW-1] ? -nz13 : nz13;

  hler_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == hler_pkg::OP_DS),
    .dividend_i (acc_mag[hler_pkg::DivW-1:0]),
    .divisor_i  (nz_mag[hler_pkg::DivisorW-1:0]),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign nf = (fc_q > hler_pkg::FcW'(hler_pkg::NumFace)) ?
              hler_pkg::FcW'(hler_pkg::NumFace) : fc_q;

  logic [hler_pkg::EdgeAW:0] ne_w;
  logic [hler_pkg::EdgeAW-1:0] ne;
  assign ne_w = {1'b0, nf, 1'b0} + {2'b00, nf};
  assign ne   = ne_w[hler_pkg::EdgeAW-1:0];

  // vertex read address
  always_comb begin
    unique case (cmd_i.op)
      hler_pkg::OP_SA: v_raddr = va_q;
      hler_pkg::OP_SB: v_raddr = vb_q;
      hler_pkg::OP_F1: v_raddr = frd.c0;
      hler_pkg::OP_F2: v_raddr = face_q.c1;
      hler_pkg::OP_F3: v_raddr = face_q.c2;
      default:         v_raddr = face_q.c0;
    endcase
  end

  // occlusion test
  logic                 shared2, inside_all, flat, pz_neg, hidden;
  logic [1:0]           nshared;
  logic signed [hler_pkg::PzW-1:0] qs, pz, zdiff;

  always_comb begin
    nshared = 2'd0;
    if (face_q.c0 == ep_a_q || face_q.c0 == ep_b_q) nshared = nshared + 2'd1;
    if (face_q.c1 == ep_a_q || face_q.c1 == ep_b_q) nshared = nshared + 2'd1;
    if (face_q.c2 == ep_a_q || face_q.c2 == ep_b_q) nshared = nshared + 2'd1;
  end

  assign shared2    = nshared >= 2'd2;
  assign inside_all = inside_q && !erd.val[VW-1];
  assign flat       = (face_q.nz == '0);
  // num / -nz is negative when signs of num and -nz differ
  assign pz_neg     = acc_q[VW-1] ^ (!face_q.nz[CW-1] && !flat);
  assign qs         = hler_pkg::PzW'({1'b0, quo});
  assign pz         = flat ? hler_pkg::PzW'(hler_pkg::FlatPlaneZ) : (pz_neg ? -qs : qs);
  assign zdiff      = hler_pkg::PzW'(pos_q[2]) - pz;
  assign hidden     = zdiff < hler_pkg::PzW'(hler_pkg::DepthMargin);

  // edge function setup operands
  hler_pkg::vertex_t vcur, vnxt;
  always_comb begin
    unique case (cidx_q)
      2'd0:    begin vcur = vtx_q[0]; vnxt = vtx_q[1]; end
      2'd1:    begin vcur = vtx_q[1]; vnxt = vtx_q[2]; end
      2'd2:    begin vcur = vtx_q[2]; vnxt = vtx_q[0]; end
      default: begin vcur = vtx_q[0]; vnxt = vtx_q[1]; end
    endcase
  end

  // shared multiplier
  logic signed [DW-1:0]   mul_a, mul_b;
  logic signed [2*DW-1:0] prod;
  always_comb begin
    unique case (cmd_i.op)
      hler_pkg::OP_E1: begin mul_a = rx_q; mul_b = ey_q; end
      hler_pkg::OP_E2: begin mul_a = ry_q; mul_b = ex_q; end
      hler_pkg::OP_M0: begin
        mul_a = DW'(face_q.nx);
        mul_b = DW'(pos_q[0]) - DW'(vtx_q[0].x);
      end
      hler_pkg::OP_M1: begin
        mul_a = DW'(face_q.ny);
        mul_b = DW'(pos_q[1]) - DW'(vtx_q[0].y);
      end
      default: begin
        mul_a = DW'(face_q.nz);
        mul_b = DW'(vtx_q[0].z);
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // incremental edge update
  logic signed [VW-1:0] inc_x, inc_y;
  assign inc_x = !mvx_q ? '0 : (sneg_q[0] ? -VW'(erd.dy) : VW'(erd.dy));
  assign inc_y = !mvy_q ? '0 : (sneg_q[1] ? -VW'(erd.dx) : VW'(erd.dx));

  always_comb begin
    e_we    = 1'b0;
    e_waddr = eaddr_q;
    ewd     = '{dy: ey_q, dx: ex_q, val: acc_q};
    if (cmd_i.op == hler_pkg::OP_E3) begin
      e_we = 1'b1;
    end else if (cmd_i.op == hler_pkg::OP_UPD && pv_q) begin
      e_we    = 1'b1;
      e_waddr = wa_q;
      ewd     = '{dy: erd.dy, dx: erd.dx, val: erd.val + inc_x - inc_y};
    end
  end

  // setup terms
  logic signed [DW-1:0] sdiff [3];
  logic [CW-1:0]        sabs [3];
  logic [CW-1:0]        dm;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sdiff[k] = '0;
    end
    sdiff[0] = DW'(vrd.x) - DW'(pos_q[0]);
    sdiff[1] = DW'(vrd.y) - DW'(pos_q[1]);
    sdiff[2] = DW'(vrd.z) - DW'(pos_q[2]);
    for (int k = 0; k < 3; k++) begin
      sabs[k] = sdiff[k][DW-1] ? CW'(-sdiff[k]) : CW'(sdiff[k]);
    end
    dm = dlt_q[0];
    if (dlt_q[1] > dm) dm = dlt_q[1];
    if (dlt_q[2] > dm) dm = dlt_q[2];
  end

  logic signed [DW-1:0] enew [3];
  logic                 mv [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      enew[k] = err_q[k] - DW'({1'b0, dlt_q[k]});
      mv[k]   = enew[k][DW-1];
    end
  end

  logic out_free;
  assign out_free = !mo_valid_q || m_axis_tready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q       <= '0;
      active_q   <= 1'b0;
      mo_valid_q <= 1'b0;
      steps_q    <= '0;
      major_q    <= '0;
      f_q        <= '0;
      cidx_q     <= '0;
      eaddr_q    <= '0;
      pv_q       <= 1'b0;
      ep_a_q     <= '0;
      ep_b_q     <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k]  <= '0;
        err_q[k]  <= '0;
        dlt_q[k]  <= '0;
        sneg_q[k] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) fc_q <= cfg_wdata_i;
      if (cmd_i.op == hler_pkg::OP_OUT && out_free) begin
        mo_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mo_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        hler_pkg::OP_IDLE: begin
          if (cmd_i.accept && in_kind == hler_pkg::KIND_STEP) begin
            f_q     <= '0;
            eaddr_q <= '0;
          end
        end
        hler_pkg::OP_SB: begin
          pos_q[0] <= vrd.x;
          pos_q[1] <= vrd.y;
          pos_q[2] <= vrd.z;
          ep_a_q   <= va_q;
          ep_b_q   <= vb_q;
        end
        hler_pkg::OP_SC: begin
          for (int k = 0; k < 3; k++) begin
            dlt_q[k]  <= sabs[k];
            sneg_q[k] <= sdiff[k][DW-1] || sdiff[k] == '0;
          end
        end
        hler_pkg::OP_SD: begin
          major_q  <= dm;
          steps_q  <= dm;
          active_q <= 1'b1;
          for (int k = 0; k < 3; k++) begin
            err_q[k] <= DW'(dm >> 1);
          end
          f_q     <= '0;
          cidx_q  <= '0;
          eaddr_q <= '0;
        end
        hler_pkg::OP_E3: begin
          eaddr_q <= eaddr_q + 1'b1;
          if (cidx_q == 2'd2) begin
            cidx_q <= '0;
            f_q    <= f_q + 1'b1;
          end else begin
            cidx_q <= cidx_q + 1'b1;
          end
        end
        hler_pkg::OP_V0, hler_pkg::OP_V1, hler_pkg::OP_V2: begin
          eaddr_q <= eaddr_q + 1'b1;
        end
        hler_pkg::OP_OUT: begin
          if (out_free) begin
            if (steps_q == '0) active_q <= 1'b0;
            else               steps_q  <= steps_q - 1'b1;
          end
        end
        hler_pkg::OP_ADV: begin
          for (int k = 0; k < 3; k++) begin
            if (mv[k]) begin
              err_q[k] <= enew[k] + DW'({1'b0, major_q});
              pos_q[k] <= sneg_q[k] ? pos_q[k] - 1'b1 : pos_q[k] + 1'b1;
            end else begin
              err_q[k] <= enew[k];
            end
          end
          eaddr_q <= '0;
          pv_q    <= 1'b0;
        end
        hler_pkg::OP_UPD: begin
          pv_q <= (eaddr_q != ne);
          if (eaddr_q != ne) eaddr_q <= eaddr_q + 1'b1;
        end
        default: ;
      endcase
      if (cmd_i.face_inc) f_q <= f_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      va_q <= in_va;
      vb_q <= in_vb;
      vis_q <= 1'b1;
    end
    if (cmd_i.clr_vis) vis_q <= 1'b0;
    wa_q <= eaddr_q;
    unique case (cmd_i.op)
      hler_pkg::OP_F1, hler_pkg::OP_V1: face_q <= frd;
      hler_pkg::OP_F2, hler_pkg::OP_V4: vtx_q[0] <= vrd;
      hler_pkg::OP_F3: vtx_q[1] <= vrd;
      hler_pkg::OP_F4: vtx_q[2] <= vrd;
      hler_pkg::OP_E0: begin
        ex_q <= DW'(vnxt.x) - DW'(vcur.x);
        ey_q <= DW'(vnxt.y) - DW'(vcur.y);
        rx_q <= DW'(pos_q[0]) - DW'(vcur.x);
        ry_q <= DW'(pos_q[1]) - DW'(vcur.y);
      end
      hler_pkg::OP_E1, hler_pkg::OP_M0: acc_q <= VW'(prod);
      hler_pkg::OP_E2, hler_pkg::OP_M2: acc_q <= acc_q - VW'(prod);
      hler_pkg::OP_M1: acc_q <= acc_q + VW'(prod);
      hler_pkg::OP_OUT: begin
        // hold the pixel while the output register is still stalled
        if (out_free) begin
          mo_x_q    <= pos_q[0];
          mo_y_q    <= pos_q[1];
          mo_vis_q  <= vis_q;
          mo_last_q <= (steps_q == '0);
        end
      end
      hler_pkg::OP_ADV: begin
        mvx_q <= mv[0];
        mvy_q <= mv[1];
      end
      default: ;
    endcase
    if (cmd_i.op == hler_pkg::OP_V0) inside_q <= 1'b1;
    // edge values of the face arrive in V1 and V2 and fold into inside_q; the last one is checked in V3
    if (cmd_i.op == hler_pkg::OP_V1 || cmd_i.op == hler_pkg::OP_V2) begin
      inside_q <= inside_q && !erd.val[VW-1];
    end
  end

  assign sts_o.nf_zero     = (nf == '0);
  assign sts_o.face_last   = (f_q + 1'b1) == nf;
  assign sts_o.corner_last = (cidx_q == 2'd2);
  assign sts_o.active      = active_q;
  assign sts_o.skip        = shared2 || !inside_all;
  assign sts_o.flat        = flat;
  assign sts_o.hidden      = hidden;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.out_free    = out_free;
  assign sts_o.upd_done    = (eaddr_q == ne) && !pv_q;
  assign sts_o.last_pix    = (steps_q == '0);

  assign m_axis_tvalid = mo_valid_q;
  assign m_axis_tdata  = {7'b0, mo_vis_q, mo_y_q, mo_x_q};
  assign m_axis_tlast  = mo_last_q;

endmodule

@@ design/hler_chk.sv @@
module hler_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic in_xact;
  assign in_xact = s_axis_tvalid && s_axis_tready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && s_axis_tuser == hler_pkg::KIND_START |=> !s_axis_tready)
    else $error("edge setup did not block input");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && (s_axis_tuser == hler_pkg::KIND_VTX || s_axis_tuser == hler_pkg::KIND_FACE)
      |=> s_axis_tready)
    else $error("load did not return to idle");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a step transaction");

endmodule

bind hidden_line_edge_rasterizer hler_chk u_chk (.*);
